>>> rtl/nsc_pkg.sv
// nsc_pkg: shared types, character codes and the hex digit decoder for the
// NMEA sentence checksum checker. No dependencies.
`default_nettype none

package nsc_pkg;

    // Sentence tracking phases
    localparam logic [1:0] PH_OUTSIDE = 2'd0;
    localparam logic [1:0] PH_BODY    = 2'd1;
    localparam logic [1:0] PH_DIGIT1  = 2'd2;
    localparam logic [1:0] PH_DIGIT2  = 2'd3;

    // Framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Digit and letter bounds for hex decoding
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;

    // Result of one character
    typedef struct packed {
        logic ok;
        logic checked;
    } t_nsc_result;

    // Hex decode: bit 4 set means "not a hex digit"
    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } t_hex_digit;

    function automatic t_hex_digit hex_decode(input logic [7:0] c);
        t_hex_digit d;
        logic [7:0] diff;
        d.bad   = 1'b0;
        d.value = 4'd0;
        diff    = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            diff    = c - CH_0;
            d.value = diff[3:0];
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            diff    = c - CH_LA + 8'd10;
            d.value = diff[3:0];
        end else if (c >= CH_UA && c <= CH_UF) begin
            diff    = c - CH_UA + 8'd10;
            d.value = diff[3:0];
        end else begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/nsc_core.sv
// nsc_core: sentence phase tracker, running XOR and checksum compare.
// Depends on nsc_pkg.
`default_nettype none

module nsc_core
    import nsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [7:0]  i_char,
    output t_nsc_result      o_result
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_first, n_first;

    t_hex_digit d1, d2;
    logic [7:0] parsed;

    always_comb begin
        d1 = hex_decode(r_first);
        d2 = hex_decode(i_char);
        if (d1.bad) begin
            parsed = 8'd0;
        end else if (d2.bad) begin
            parsed = {4'd0, d1.value};
        end else begin
            parsed = {d1.value, d2.value};
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_xor            = r_xor;
        n_first          = r_first;
        o_result.ok      = 1'b1;
        o_result.checked = 1'b0;
        unique case (r_phase)
            PH_OUTSIDE: begin
                if (i_char == CH_DOLLAR || i_char == CH_BANG) begin
                    n_xor   = 8'd0;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (i_char == CH_STAR) begin
                    n_phase = PH_DIGIT1;
                end else begin
                    // CR/LF still folds into the XOR, then drops the sentence
                    n_xor = r_xor ^ i_char;
                    if (i_char == CH_CR || i_char == CH_LF) begin
                        n_phase = PH_OUTSIDE;
                    end
                end
            end
            PH_DIGIT1: begin
                n_first = i_char;
                n_phase = PH_DIGIT2;
            end
            PH_DIGIT2: begin
                n_phase          = PH_OUTSIDE;
                o_result.checked = 1'b1;
                o_result.ok      = (parsed == r_xor);
            end
            default: begin
                n_phase = PH_OUTSIDE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OUTSIDE;
            r_xor   <= 8'd0;
            r_first <= 8'd0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_first <= n_first;
        end
    end

`ifndef SYNTHESIS
    a_check_ends_sentence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_DIGIT2) |=> (r_phase == PH_OUTSIDE))
        else $error("phase did not return outside after checksum compare");
    a_star_to_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_BODY && i_char == CH_STAR) |=> (r_phase == PH_DIGIT1))
        else $error("star in body did not start checksum capture");
    a_start_clears_xor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_OUTSIDE && (i_char == CH_DOLLAR || i_char == CH_BANG))
        |=> (r_xor == 8'd0))
        else $error("start character did not clear running XOR");
`endif

endmodule

`default_nettype wire

>>> rtl/nmea_sentence_checksum_checker_top.sv
// nmea_sentence_checksum_checker_top: input register, sentence tracker and
// result register with valid/stall handshakes. Depends on nsc_pkg, nsc_core.
`default_nettype none

// Checks NMEA-style sentence checksums one received character per request.
// Every accepted character gives exactly one result request: checksum_ok is 0
// only for the second checksum digit of a sentence whose parsed hex value
// differs from the XOR of its body; sentence_checked marks that digit. A '$'
// or '!' outside a sentence starts one, '*' ends the body, CR or LF abandons
// it. Throughput is one character per clock while the result register is not
// stalled downstream; a character passes the input register and then the result
// register, with the phase/XOR update and compare done in the single
// combinational pass between them. o_in_stall rises only when a character
// waits in the input register and the result register is full and stalled downstream.
module nmea_sentence_checksum_checker_top
    import nsc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // character requests
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_char,
    // result requests
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_checksum_ok,
    output logic            o_sentence_checked
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_out_valid;
    t_nsc_result r_out;

    logic        out_free;
    logic        advance;
    logic        in_take;
    t_nsc_result core_result;

    // Result slot frees up when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    nsc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_char   (r_in_char),
        .o_result (core_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_rx_char;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_checksum_ok      = r_out.ok;
    assign o_sentence_checked = r_out.checked;

`ifndef SYNTHESIS
    a_ok_unless_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sentence_checked) |-> o_checksum_ok)
        else $error("mismatch flagged without a checksum compare");
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with no pending character");
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced character produced no result");
`endif

endmodule

`default_nettype wire
